// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define FCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// Frustum containment test package
// Types and fixed widths shared by the frustum test modules.
// ----------------------------------------------------------------------------
package fct_pkg;

   localparam int PLANE_REGS = 6;   // plane registers in the CSR space
   localparam int CSR_IDX_W  = 3;
   localparam int PLANE_W    = 64;
   localparam int COEF_W     = 16;
   localparam int POS_W      = 16;
   localparam int EXT_W      = 15;
   localparam int MAG_W      = COEF_W + 1;
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 36;
   // Q2.14 times Q12.4 has 18 fraction bits; Q12.4 terms are shifted up by this.
   localparam int FRAC_ALIGN = 14;

   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_CUBE   = 2'd1,
      OP_BOX    = 2'd2,
      OP_SPHERE = 2'd3
   } fct_op_type;

   typedef struct packed {
      fct_op_type              op;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [EXT_W-1:0]        ext_x;
      logic [EXT_W-1:0]        ext_y;
      logic [EXT_W-1:0]        ext_z;
   } fct_query_type;

   // Load enables of the per-plane pipeline stages.
   typedef struct packed {
      logic en_b;
      logic en_c;
      logic en_d;
   } fct_ctl_type;

endpackage

// File: rtl/fct_if.sv
// ----------------------------------------------------------------------------
// Frustum containment test channels
// Query, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fct_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic signed [15:0]  pos_x;
   logic signed [15:0]  pos_y;
   logic signed [15:0]  pos_z;
   logic [14:0]         ext_x;
   logic [14:0]         ext_y;
   logic [14:0]         ext_z;

   modport source (output valid, op, pos_x, pos_y, pos_z, ext_x, ext_y, ext_z,
                   input ready);
   modport sink   (input valid, op, pos_x, pos_y, pos_z, ext_x, ext_y, ext_z,
                   output ready);
endinterface

interface fct_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

interface fct_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/frustum_containment_test.sv
// ----------------------------------------------------------------------------
// Frustum containment test
// Tests a point, cube, box or sphere against up to six frustum planes.
// ----------------------------------------------------------------------------
// The six plane registers are written on the csr channel (index 0 to 5, near,
// far, left, right, top, bottom); writes to other indexes are dropped. Write
// them only while no query is in flight. Each query word on req yields one
// word on rsp with inside_res set when the primitive is inside or touches the
// frustum.
// The pipeline has five register stages: input capture, products, partial
// sums, per-plane sign, and the output register. One query is taken every
// cycle while rsp accepts results. When rsp is stalled the stages fill one
// by one and req.ready falls only once every stage holds a word; nothing is
// dropped or repeated.
// Reset empties the pipeline and clears all planes to zero, which makes
// every primitive test as inside.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frustum_containment_test
   import fct_pkg::*;
#(
   parameter int PLANE_COUNT = 6
)
(
   input  logic     clock,
   input  logic     reset,
   fct_req_if.sink  req,
   fct_rsp_if.source rsp,
   fct_csr_if.sink  csr
);

   logic [PLANE_W-1:0] plane_ff [PLANE_REGS];

   fct_query_type      query_a_ff, query_a_in;
   logic               v_a_ff, v_b_ff, v_c_ff, v_d_ff, v_e_ff;
   logic               rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
   fct_ctl_type        ctl;
   logic [PLANE_COUNT-1:0] fail_d;
   logic               inside_ff;

   // Register writes.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_REGS; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr.valid && (int'(csr.index) < PLANE_REGS)) begin
         plane_ff[csr.index] <= csr.wdata;
      end
   end

   // A stage loads when it is empty or its word moves on this cycle.
   assign rdy_e = !v_e_ff || rsp.ready;
   assign rdy_d = !v_d_ff || rdy_e;
   assign rdy_c = !v_c_ff || rdy_d;
   assign rdy_b = !v_b_ff || rdy_c;
   assign rdy_a = !v_a_ff || rdy_b;

   assign req.ready = rdy_a;
   assign ctl.en_b  = rdy_b;
   assign ctl.en_c  = rdy_c;
   assign ctl.en_d  = rdy_d;

   // A cube uses its one half size on all three axes.
   always_comb begin
      query_a_in.op    = fct_op_type'(req.op);
      query_a_in.pos_x = req.pos_x;
      query_a_in.pos_y = req.pos_y;
      query_a_in.pos_z = req.pos_z;
      query_a_in.ext_x = req.ext_x;
      query_a_in.ext_y = (fct_op_type'(req.op) == OP_CUBE) ? req.ext_x : req.ext_y;
      query_a_in.ext_z = (fct_op_type'(req.op) == OP_CUBE) ? req.ext_x : req.ext_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
      end else begin
         if (rdy_a) v_a_ff <= req.valid;
         if (rdy_b) v_b_ff <= v_a_ff;
         if (rdy_c) v_c_ff <= v_b_ff;
         if (rdy_d) v_d_ff <= v_c_ff;
         if (rdy_e) v_e_ff <= v_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         query_a_ff <= query_a_in;
      end
      if (rdy_e) begin
         inside_ff <= ~|fail_d;
      end
   end

   for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
      fct_plane_eval u_eval (
         .clock (clock),
         .ctl   (ctl),
         .plane (plane_ff[g]),
         .query (query_a_ff),
         .fail  (fail_d[g])
      );
   end

   assign rsp.valid      = v_e_ff;
   assign rsp.inside_res = inside_ff;

   `FCT_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp.valid,
      "result valid right after reset")
   `FCT_ASSERT(a_ready_on_bubble, clock, reset, !v_a_ff |-> req.ready,
      "input refused although the first stage is empty")
   `FCT_ASSERT(a_stall_holds, clock, reset, (v_d_ff && !rdy_e) |=> v_d_ff,
      "word lost in the sign stage during an output stall")
   `FCT_ASSERT(a_bubble_moves, clock, reset, (rdy_d && !v_c_ff) |=> !v_d_ff,
      "word invented in the sign stage")

endmodule

// File: rtl/fct_plane_eval.sv
// ----------------------------------------------------------------------------
// Frustum plane evaluator
// Three-stage datapath that decides whether a query lies wholly behind one
// plane: products, partial sums, then the sign of the total.
// ----------------------------------------------------------------------------
module fct_plane_eval
   import fct_pkg::*;
(
   input  logic                 clock,
   input  fct_ctl_type          ctl,
   input  logic [PLANE_W-1:0]   plane,
   input  fct_query_type        query,
   output logic                 fail
);

   logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
   logic signed [MAG_W-1:0]  sx_a, sx_b, sx_c;
   logic [MAG_W-1:0]         mag_a, mag_b, mag_c;

   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;
   logic [PROD_W-1:0]        qa_ff, qb_ff, qc_ff, qa_in, qb_in, qc_in;
   logic signed [COEF_W-1:0] d_ff;

   logic signed [SUM_W-1:0]  base_ff, base_in;
   logic [SUM_W-1:0]         slack_ff, slack_in;
   logic signed [SUM_W-1:0]  total;
   logic                     fail_ff;

   assign coef_a = plane[15:0];
   assign coef_b = plane[31:16];
   assign coef_c = plane[47:32];
   assign coef_d = plane[63:48];

   assign sx_a  = MAG_W'(coef_a);
   assign sx_b  = MAG_W'(coef_b);
   assign sx_c  = MAG_W'(coef_c);
   assign mag_a = sx_a[MAG_W-1] ? MAG_W'(-sx_a) : MAG_W'(sx_a);
   assign mag_b = sx_b[MAG_W-1] ? MAG_W'(-sx_b) : MAG_W'(sx_b);
   assign mag_c = sx_c[MAG_W-1] ? MAG_W'(-sx_c) : MAG_W'(sx_c);

   // The farthest corner along the normal adds |a|*ex + |b|*ey + |c|*ez to the
   // center value, so a box is outside only if that maximum stays negative.
   always_comb begin
      pa_in = PROD_W'(coef_a) * PROD_W'(query.pos_x);
      pb_in = PROD_W'(coef_b) * PROD_W'(query.pos_y);
      pc_in = PROD_W'(coef_c) * PROD_W'(query.pos_z);
      qa_in = '0;
      qb_in = '0;
      qc_in = '0;
      case (query.op)
         OP_CUBE, OP_BOX: begin
            qa_in = PROD_W'(mag_a) * PROD_W'(query.ext_x);
            qb_in = PROD_W'(mag_b) * PROD_W'(query.ext_y);
            qc_in = PROD_W'(mag_c) * PROD_W'(query.ext_z);
         end
         OP_SPHERE: begin
            qa_in = PROD_W'(query.ext_x) << FRAC_ALIGN;
         end
         default: begin
         end
      endcase
   end

   assign base_in  = SUM_W'(pa_ff) + SUM_W'(pb_ff) + SUM_W'(pc_ff)
                   + (SUM_W'(d_ff) <<< FRAC_ALIGN);
   assign slack_in = SUM_W'(qa_ff) + SUM_W'(qb_ff) + SUM_W'(qc_ff);
   assign total    = base_ff + $signed(slack_ff);

   always_ff @(posedge clock) begin
      if (ctl.en_b) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
         qa_ff <= qa_in;
         qb_ff <= qb_in;
         qc_ff <= qc_in;
         d_ff  <= coef_d;
      end
      if (ctl.en_c) begin
         base_ff  <= base_in;
         slack_ff <= slack_in;
      end
      if (ctl.en_d) begin
         fail_ff <= total[SUM_W-1];
      end
   end

   assign fail = fail_ff;

endmodule

// File: sim/frustum_containment_test_test.sv
// ----------------------------------------------------------------------------
// Frustum containment test bench
// Sends point, cube, box and sphere queries through the block under a range
// of plane sets, with random gaps and back-pressure on both channels. A
// scoreboard computes each expected inside flag exactly and compares it with
// the result words in order.
// ----------------------------------------------------------------------------
module frustum_containment_test_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fct_pkg::*;

   localparam int TB_PLANES   = 6;
   localparam int DRAIN_LIMIT = 2000;

   class containment_board;
      bit [PLANE_W-1:0] planes [PLANE_REGS];
      bit               expected_inside [$];
      int               op_count [4];
      int               results_checked;
      int               mismatches;

      function void set_plane(int idx, bit [PLANE_W-1:0] value);
         if (idx < PLANE_REGS) planes[idx] = value;
      endfunction

      // Plane value with 18 fraction bits; coordinates are Q12.4 integers.
      function longint plane_value(int p, longint x, longint y, longint z);
         longint a, b, c, d;
         a = shortint'(planes[p][15:0]);
         b = shortint'(planes[p][31:16]);
         c = shortint'(planes[p][47:32]);
         d = shortint'(planes[p][63:48]);
         return a * x + b * y + c * z + d * (1 << FRAC_ALIGN);
      endfunction

      function void note_query(fct_query_type q);
         longint px, py, pz, ex, ey, ez, cx, cy, cz;
         bit     in_frustum, touched;
         px = longint'($signed(q.pos_x));
         py = longint'($signed(q.pos_y));
         pz = longint'($signed(q.pos_z));
         ex = longint'(q.ext_x);
         ey = longint'(q.ext_y);
         ez = longint'(q.ext_z);
         if (q.op == OP_CUBE) begin
            ey = ex;
            ez = ex;
         end
         in_frustum = 1'b1;
         for (int p = 0; p < TB_PLANES; p++) begin
            case (q.op)
               OP_POINT: begin
                  if (plane_value(p, px, py, pz) < 0) in_frustum = 1'b0;
               end
               OP_SPHERE: begin
                  if (plane_value(p, px, py, pz) < -(ex * (1 << FRAC_ALIGN)))
                     in_frustum = 1'b0;
               end
               default: begin
                  // The primitive is culled only if every corner is behind this plane.
                  touched = 1'b0;
                  for (int k = 0; k < 8; k++) begin
                     cx = k[0] ? px + ex : px - ex;
                     cy = k[1] ? py + ey : py - ey;
                     cz = k[2] ? pz + ez : pz - ez;
                     if (plane_value(p, cx, cy, cz) >= 0) touched = 1'b1;
                  end
                  if (!touched) in_frustum = 1'b0;
               end
            endcase
         end
         op_count[int'(q.op)]++;
         expected_inside.push_back(in_frustum);
      endfunction

      function void check_result(logic got);
         bit want;
         if (expected_inside.size() == 0) begin
            $display("%0t: result word with no query pending, actual inside_res=%0b",
                     $time, got);
            mismatches++;
            return;
         end
         want = expected_inside.pop_front();
         results_checked++;
         if (got !== want) begin
            $display("%0t: inside_res mismatch, expected %0b, actual %0b", $time, want, got);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_inside.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   hold_request;
   int   plane_writes;

   fct_req_if req_if ();
   fct_rsp_if rsp_if ();
   fct_csr_if csr_if ();

   containment_board board = new();

   frustum_containment_test #(.PLANE_COUNT(TB_PLANES)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 13);
   endfunction

   function automatic fct_query_type make_query(fct_op_type op, int x, int y, int z,
                                                 int ex, int ey, int ez);
      fct_query_type q;
      q.op    = op;
      q.pos_x = x[15:0];
      q.pos_y = y[15:0];
      q.pos_z = z[15:0];
      q.ext_x = ex[14:0];
      q.ext_y = ey[14:0];
      q.ext_z = ez[14:0];
      return q;
   endfunction

   function automatic bit [63:0] pack_plane(bit [15:0] a, bit [15:0] b, bit [15:0] c,
                                            bit [15:0] d);
      return {d, c, b, a};
   endfunction

   task automatic send_query(fct_query_type q);
      @(negedge clock);
      while (take_gap()) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op    <= q.op;
      req_if.pos_x <= q.pos_x;
      req_if.pos_y <= q.pos_y;
      req_if.pos_z <= q.pos_z;
      req_if.ext_x <= q.ext_x;
      req_if.ext_y <= q.ext_y;
      req_if.ext_z <= q.ext_z;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_query(q);
   endtask

   task automatic write_plane(int idx, bit [63:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx[2:0];
      csr_if.wdata <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      board.set_plane(idx, value);
      plane_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Stops offering queries and waits until every pending result has come back or the drain limit runs out.
   task automatic drain_results();
      int waited;
      @(negedge clock);
      req_if.valid <= 1'b0;
      waited = 0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Result side: random stalls, plus long hold-offs on request.
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !take_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_result(rsp_if.inside_res);
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      fct_query_type q;
      bit [63:0]     pv;
      int            leftover;

      req_if.valid = 1'b0;
      req_if.op    = '0;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      req_if.pos_z = '0;
      req_if.ext_x = '0;
      req_if.ext_y = '0;
      req_if.ext_z = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.wdata = '0;
      steady       = 1'b0;
      hold_request = 0;
      plane_writes = 0;
      reset        = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // All planes are zero after reset, so everything must test inside.
      send_query(make_query(OP_POINT, -32768, -32768, -32768, 32767, 32767, 32767));
      send_query(make_query(OP_CUBE, 32767, 32767, 32767, 32767, 0, 0));
      send_query(make_query(OP_BOX, -32768, 32767, -32768, 32767, 32767, 32767));
      send_query(make_query(OP_SPHERE, 32767, -32768, 0, 0, 0, 0));

      // Axis-aligned frustum: each coordinate limited to +/-100.0 (1600 in Q12.4).
      drain_results();
      write_plane(0, pack_plane(16'h0000, 16'h0000, 16'h4000, 16'd1600));
      write_plane(1, pack_plane(16'h0000, 16'h0000, 16'hC000, 16'd1600));
      write_plane(2, pack_plane(16'h4000, 16'h0000, 16'h0000, 16'd1600));
      write_plane(3, pack_plane(16'hC000, 16'h0000, 16'h0000, 16'd1600));
      write_plane(4, pack_plane(16'h0000, 16'hC000, 16'h0000, 16'd1600));
      write_plane(5, pack_plane(16'h0000, 16'h4000, 16'h0000, 16'd1600));
      send_query(make_query(OP_POINT, 0, 0, 0, 0, 0, 0));
      send_query(make_query(OP_POINT, 1600, -1600, 1600, 0, 0, 0));
      send_query(make_query(OP_POINT, 1601, 0, 0, 0, 0, 0));
      send_query(make_query(OP_POINT, 0, 0, -1601, 32767, 32767, 32767));
      send_query(make_query(OP_CUBE, 1700, 0, 0, 100, 0, 0));
      send_query(make_query(OP_CUBE, 1700, 0, 0, 99, 32767, 32767));
      send_query(make_query(OP_BOX, 1700, 0, 0, 100, 0, 0));
      send_query(make_query(OP_BOX, 1700, 0, 0, 99, 32767, 32767));
      send_query(make_query(OP_BOX, 0, -1800, 0, 0, 200, 0));
      send_query(make_query(OP_SPHERE, 1700, 0, 0, 100, 0, 0));
      send_query(make_query(OP_SPHERE, 1700, 0, 0, 99, 32767, 32767));
      send_query(make_query(OP_SPHERE, 32767, 32767, 32767, 32767, 0, 0));
      send_query(make_query(OP_POINT, -32768, -32768, -32768, 0, 0, 0));
      send_query(make_query(OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767));

      // Extreme coefficients; writes past the last plane must be dropped.
      drain_results();
      write_plane(0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_plane(1, pack_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      write_plane(2, pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h8000));
      write_plane(3, pack_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
      write_plane(4, 64'h0);
      write_plane(5, 64'h0);
      write_plane(6, 64'h8000_8000_8000_8000);
      write_plane(7, 64'h8000_8000_8000_8000);
      send_query(make_query(OP_POINT, 32767, 32767, 32767, 0, 0, 0));
      send_query(make_query(OP_CUBE, -32768, -32768, -32768, 32767, 0, 0));
      send_query(make_query(OP_BOX, 0, 0, 0, 32767, 32767, 32767));
      send_query(make_query(OP_SPHERE, -32768, -32768, -32768, 32767, 0, 0));

      for (int phase = 0; phase < 10; phase++) begin
         drain_results();
         for (int i = 0; i < TB_PLANES; i++) begin
            if (phase == 3) begin
               pv = {$urandom, $urandom};
            end else if (phase == 9 && i[0] == 1'b0) begin
               pv = 64'h0;
            end else begin
               // Roughly normalized plane with the origin on the inner side.
               pv = pack_plane(16'($urandom_range(32768) - 16384),
                               16'($urandom_range(32768) - 16384),
                               16'($urandom_range(32768) - 16384),
                               16'($urandom_range(16000)));
            end
            write_plane(i, pv);
         end
         if ($urandom_range(1) == 1) write_plane($urandom_range(7, 6), {$urandom, $urandom});
         steady = (phase == 4);
         for (int n = 0; n < 125; n++) begin
            q.op = fct_op_type'($urandom_range(3));
            if ($urandom_range(9) < 7) begin
               q.pos_x = 16'($urandom_range(6000) - 3000);
               q.pos_y = 16'($urandom_range(6000) - 3000);
               q.pos_z = 16'($urandom_range(6000) - 3000);
            end else begin
               q.pos_x = 16'($urandom);
               q.pos_y = 16'($urandom);
               q.pos_z = 16'($urandom);
            end
            if ($urandom_range(9) < 6) begin
               q.ext_x = 15'($urandom_range(500));
               q.ext_y = 15'($urandom_range(500));
               q.ext_z = 15'($urandom_range(500));
            end else begin
               q.ext_x = 15'($urandom);
               q.ext_y = 15'($urandom);
               q.ext_z = 15'($urandom);
            end
            send_query(q);
            // Long result stall while queries keep coming, so the pipeline backs up.
            if (phase == 2 && n == 40) hold_request = 80;
            if (phase == 6 && n == 60) drain_results();
         end
         steady = 1'b0;
      end

      drain_results();
      leftover = board.pending();
      if (leftover != 0)
         $display("%0t: %0d expected results never arrived", $time, leftover);
      $display("tb: covered %0d point, %0d cube, %0d box and %0d sphere queries, %0d checked",
               board.op_count[0], board.op_count[1], board.op_count[2], board.op_count[3],
               board.results_checked);
      $display("tb: %0d plane register writes, including extreme and out-of-range ones",
               plane_writes);
      if (board.mismatches == 0 && leftover == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/fct_pkg.sv
rtl/fct_if.sv
rtl/fct_plane_eval.sv
rtl/frustum_containment_test.sv
sim/frustum_containment_test_test.sv
